// ===== sv/sstd_pkg.sv =====
// ----------------------------------------------------------------------------
// sstd_pkg
// shared types, constants and the odd prime table of the smoothness tester
// ----------------------------------------------------------------------------
package sstd_pkg;

  localparam int unsigned MaxBaseDefault = 32;
  localparam int unsigned OddPrimeCount  = 72;
  localparam int unsigned PrimeW         = 9;
  localparam int unsigned ExpW           = 6;
  localparam int unsigned QW             = 64;
  localparam int unsigned NW             = 32;
  localparam int unsigned TabIdxW        = 7;

  localparam logic [NW-1:0]     NReset     = 32'd16157;
  localparam logic [PrimeW-1:0] LimitReset = 9'd30;
  localparam logic [PrimeW-1:0] PrimeTwo   = 9'd2;

  // configuration register indexes
  localparam logic [0:0] RegNValue     = 1'b0;
  localparam logic [0:0] RegPrimeLimit = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD_INIT,
    ST_BUILD_POW,
    ST_BUILD_NEXT,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  // control handed from the sequencer to each cell of the chain
  typedef struct packed {
    logic load;   // load (not connected to any cell of the chain)
    logic shift;  // pass prime and exponent one cell along
  } cell_ctl_t;

  function automatic logic [PrimeW-1:0] odd_prime(input logic [TabIdxW-1:0] idx);
    logic [PrimeW-1:0] p;
    case (idx)
      7'd0: p = 9'd3;     7'd1: p = 9'd5;     7'd2: p = 9'd7;     7'd3: p = 9'd11;
      7'd4: p = 9'd13;    7'd5: p = 9'd17;    7'd6: p = 9'd19;    7'd7: p = 9'd23;
      7'd8: p = 9'd29;    7'd9: p = 9'd31;    7'd10: p = 9'd37;   7'd11: p = 9'd41;
      7'd12: p = 9'd43;   7'd13: p = 9'd47;   7'd14: p = 9'd53;   7'd15: p = 9'd59;
      7'd16: p = 9'd61;   7'd17: p = 9'd67;   7'd18: p = 9'd71;   7'd19: p = 9'd73;
      7'd20: p = 9'd79;   7'd21: p = 9'd83;   7'd22: p = 9'd89;   7'd23: p = 9'd97;
      7'd24: p = 9'd101;  7'd25: p = 9'd103;  7'd26: p = 9'd107;  7'd27: p = 9'd109;
      7'd28: p = 9'd113;  7'd29: p = 9'd127;  7'd30: p = 9'd131;  7'd31: p = 9'd137;
      7'd32: p = 9'd139;  7'd33: p = 9'd149;  7'd34: p = 9'd151;  7'd35: p = 9'd157;
      7'd36: p = 9'd163;  7'd37: p = 9'd167;  7'd38: p = 9'd173;  7'd39: p = 9'd179;
      7'd40: p = 9'd181;  7'd41: p = 9'd191;  7'd42: p = 9'd193;  7'd43: p = 9'd197;
      7'd44: p = 9'd199;  7'd45: p = 9'd211;  7'd46: p = 9'd223;  7'd47: p = 9'd227;
      7'd48: p = 9'd229;  7'd49: p = 9'd233;  7'd50: p = 9'd239;  7'd51: p = 9'd241;
      7'd52: p = 9'd251;  7'd53: p = 9'd257;  7'd54: p = 9'd263;  7'd55: p = 9'd269;
      7'd56: p = 9'd271;  7'd57: p = 9'd277;  7'd58: p = 9'd281;  7'd59: p = 9'd283;
      7'd60: p = 9'd293;  7'd61: p = 9'd307;  7'd62: p = 9'd311;  7'd63: p = 9'd313;
      7'd64: p = 9'd317;  7'd65: p = 9'd331;  7'd66: p = 9'd337;  7'd67: p = 9'd347;
      7'd68: p = 9'd349;  7'd69: p = 9'd353;  7'd70: p = 9'd359;  7'd71: p = 9'd367;
      default: p = 9'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/sstd_divmod.sv =====
// ----------------------------------------------------------------------------
// sstd_divmod
// radix-2 restoring divider of a 64-bit value by a 9-bit prime
// ----------------------------------------------------------------------------
module sstd_divmod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sstd_pkg::QW-1:0]       dividend,
  input  logic [sstd_pkg::PrimeW-1:0]   divisor,
  output logic                          done,
  output logic [sstd_pkg::QW-1:0]       quotient,
  output logic [sstd_pkg::PrimeW-1:0]   remainder
);

  localparam int unsigned CntW = $clog2(sstd_pkg::QW) + 1;

  logic                        busy_r, busy_nxt;
  logic [CntW-1:0]             cnt_r, cnt_nxt;
  logic [sstd_pkg::QW-1:0]     quo_r, quo_nxt;
  logic [sstd_pkg::PrimeW-1:0] rem_r, rem_nxt;
  logic [sstd_pkg::PrimeW-1:0] div_r, div_nxt;
  logic                        done_r, done_nxt;
  logic [sstd_pkg::PrimeW:0]   trial;

  // one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[sstd_pkg::QW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(sstd_pkg::QW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = sstd_pkg::PrimeW'(trial - {1'b0, div_r});
        quo_nxt = {quo_r[sstd_pkg::QW-2:0], 1'b1};
      end else begin
        rem_nxt = sstd_pkg::PrimeW'(trial);
        quo_nxt = {quo_r[sstd_pkg::QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== sv/sstd_cell.sv =====
// ----------------------------------------------------------------------------
// sstd_cell
// one slot of the result chain: holds a base prime and its exponent
// ----------------------------------------------------------------------------
module sstd_cell (
  input  logic                        clk,
  input  logic                        shift,
  input  logic                        prime_wr,
  input  logic [sstd_pkg::PrimeW-1:0] prime_in,
  input  logic                        exp_wr,
  input  logic [sstd_pkg::ExpW-1:0]   exp_in,
  input  logic [sstd_pkg::PrimeW-1:0] prime_prev,
  input  logic [sstd_pkg::ExpW-1:0]   exp_prev,
  output logic [sstd_pkg::PrimeW-1:0] prime_out,
  output logic [sstd_pkg::ExpW-1:0]   exp_out
);

  logic [sstd_pkg::PrimeW-1:0] prime_r;
  logic [sstd_pkg::ExpW-1:0]   exp_r;

  // rotate along the chain (the tail may take a fresh exponent), or take a prime write
  always_ff @(posedge clk) begin
    if (shift) begin
      prime_r <= prime_prev;
      exp_r   <= exp_wr ? exp_in : exp_prev;
    end else begin
      if (prime_wr) begin
        prime_r <= prime_in;
      end
    end
  end

  assign prime_out = prime_r;
  assign exp_out   = exp_r;

endmodule

// ===== sv/sieve_smoothness_trial_divider.sv =====
// ----------------------------------------------------------------------------
// sieve_smoothness_trial_divider
// quadratic sieve smoothness test by trial division over a factor base
// ----------------------------------------------------------------------------
// The factor base is held in a ring of cells as long as the base; cell 0
// always carries the prime under work and the ring rotates one step per
// prime, the finished exponent entering at the tail. Each trial division of
// the 64-bit value by a prime uses a shared bit-serial divider. Building the
// base after reset or a register write runs the Euler power on each odd
// table prime tried, using the same divider for the reduction of N and for
// each modular product. A new candidate is taken only after every result of
// the previous one has been transferred.
// ----------------------------------------------------------------------------
module sieve_smoothness_trial_divider #(
  parameter int unsigned MAX_BASE = sstd_pkg::MaxBaseDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 in_candidate_x,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [8:0]                  out_base_prime,
  output logic [5:0]                  out_exponent,
  output logic [63:0]                 out_cofactor,
  output logic                        out_is_smooth,
  output logic                        out_status,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [31:0]                 cfg_data
);

  localparam int unsigned SzW = $clog2(MAX_BASE + 1);
  localparam int unsigned PW  = sstd_pkg::PrimeW;
  localparam int unsigned EW  = sstd_pkg::ExpW;
  localparam int unsigned QW  = sstd_pkg::QW;

  sstd_pkg::state_t state_r, state_nxt;

  logic [31:0]     n_r;
  logic [PW-1:0]   limit_r;
  logic            ready_r;
  logic [SzW-1:0]  size_r;
  logic [SzW-1:0]  cnt_r;
  logic [sstd_pkg::TabIdxW-1:0] tab_r;
  logic [PW-1:0]   acc_r;
  logic [PW-1:0]   r_r;
  logic [PW-1:0]   pow_r;
  logic            pow_mul_r;   // 0: reducing n, 1: reducing product
  logic            x_pend_r;
  logic [31:0]     x_r;
  logic [QW-1:0]   q_r;
  logic            err_r;
  logic [EW-1:0]   e_r;
  logic            dv_busy_r;

  // chain signals
  logic [PW-1:0] c_prime [MAX_BASE];
  logic [EW-1:0] c_exp   [MAX_BASE];
  sstd_pkg::cell_ctl_t ctl;
  logic          wr_prime, wr_exp;
  logic [PW-1:0] wr_prime_val;
  logic [SzW-1:0] wr_slot;

  // divider
  logic          dv_start, dv_done;
  logic [QW-1:0] dv_a, dv_q;
  logic [PW-1:0] dv_b, dv_r;

  logic [PW-1:0]   tab_p;
  logic [QW-1:0]   sq;
  logic            out_fire;
  logic [PW-1:0]   mul_b;
  logic [2*PW-1:0] pow_prod;

  assign tab_p    = sstd_pkg::odd_prime(tab_r);
  assign sq       = QW'(x_r) * QW'(x_r);
  assign out_fire = out_valid && !out_stall;
  // one candidate at a time, counting the cycle it waits in idle
  assign in_stall = (state_r != sstd_pkg::ST_IDLE) || x_pend_r;

  // next modular product: r times r, times one for a half exponent of one,
  // or the running power times r
  assign mul_b    = pow_mul_r ? r_r : ((pow_r == 9'd1) ? 9'd1 : dv_r);
  assign pow_prod = {{PW{1'b0}}, dv_r} * {{PW{1'b0}}, mul_b};

  sstd_divmod u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
    .divisor(dv_b), .done(dv_done), .quotient(dv_q), .remainder(dv_r)
  );

  // row of cells, rotating toward cell 0; the last cell of the base takes from cell 0
  for (genvar i = 0; i < MAX_BASE; i++) begin : g_cell
    logic is_tail;
    assign is_tail = (size_r == SzW'(i + 1));
    sstd_cell u_cell (
      .clk(clk), .shift(ctl.shift),
      .prime_wr(wr_prime && (wr_slot == SzW'(i))), .prime_in(wr_prime_val),
      .exp_wr(wr_exp && is_tail), .exp_in(e_r),
      .prime_prev(is_tail ? c_prime[0] : c_prime[(i + 1) % MAX_BASE]),
      .exp_prev(is_tail ? c_exp[0] : c_exp[(i + 1) % MAX_BASE]),
      .prime_out(c_prime[i]), .exp_out(c_exp[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sstd_pkg::ST_IDLE:
        if (x_pend_r) state_nxt = ready_r ? sstd_pkg::ST_DIVIDE : sstd_pkg::ST_BUILD_INIT;
      sstd_pkg::ST_BUILD_INIT: state_nxt = sstd_pkg::ST_BUILD_NEXT;
      sstd_pkg::ST_BUILD_NEXT:
        if (size_r == SzW'(MAX_BASE) || tab_r == sstd_pkg::TabIdxW'(sstd_pkg::OddPrimeCount)
            || tab_p >= limit_r)
          state_nxt = sstd_pkg::ST_DIVIDE;
        else
          state_nxt = sstd_pkg::ST_BUILD_POW;
      sstd_pkg::ST_BUILD_POW:
        if (dv_done && pow_mul_r && pow_r <= 9'd1) state_nxt = sstd_pkg::ST_BUILD_NEXT;
      sstd_pkg::ST_DIVIDE:
        if (err_r || (cnt_r == size_r && !dv_busy_r)) state_nxt = sstd_pkg::ST_EMIT;
      sstd_pkg::ST_EMIT:
        if (out_fire && out_last) state_nxt = sstd_pkg::ST_IDLE;
      default: state_nxt = sstd_pkg::ST_IDLE;
    endcase
  end

  // datapath control outputs
  always_comb begin
    dv_start     = 1'b0;
    dv_a         = q_r;
    dv_b         = c_prime[0];
    ctl          = '0;
    wr_prime     = 1'b0;
    wr_exp       = 1'b0;
    wr_prime_val = tab_p;
    wr_slot      = size_r;
    case (state_r)
      sstd_pkg::ST_BUILD_INIT: begin
        wr_prime     = 1'b1;
        wr_prime_val = sstd_pkg::PrimeTwo;
        wr_slot      = '0;
      end
      sstd_pkg::ST_BUILD_NEXT:
        if (state_nxt == sstd_pkg::ST_BUILD_POW) begin
          dv_start = 1'b1;
          dv_a     = QW'(n_r);
          dv_b     = tab_p;
        end
      sstd_pkg::ST_BUILD_POW: begin
        dv_b = tab_p;
        if (dv_done) begin
          if (pow_mul_r && pow_r <= 9'd1) begin
            wr_prime = (dv_r == 9'd1);
          end else begin
            dv_start = 1'b1;
            dv_a     = QW'(pow_prod);
          end
        end
      end
      sstd_pkg::ST_DIVIDE:
        if (!err_r && cnt_r != size_r) begin
          if (!dv_busy_r) begin
            dv_start = 1'b1;
          end else if (dv_done && dv_r != '0) begin
            wr_exp    = 1'b1;
            ctl.shift = 1'b1;
          end
        end
      sstd_pkg::ST_EMIT:
        ctl.shift = out_fire && !err_r;
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sstd_pkg::ST_IDLE;
      n_r      <= sstd_pkg::NReset;
      limit_r  <= sstd_pkg::LimitReset;
      ready_r  <= 1'b0;
      size_r   <= '0;
      x_pend_r <= 1'b0;
      dv_busy_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          sstd_pkg::RegNValue:     n_r <= cfg_data;
          sstd_pkg::RegPrimeLimit: limit_r <= cfg_data[PW-1:0];
          default: ;
        endcase
        ready_r <= 1'b0;
      end
      if (in_valid && !in_stall) begin
        x_pend_r <= 1'b1;
        x_r      <= in_candidate_x;
      end
      case (state_r)
        sstd_pkg::ST_IDLE:
          if (x_pend_r) begin
            x_pend_r <= 1'b0;
            tab_r    <= '0;
            cnt_r    <= '0;
            e_r      <= '0;
            dv_busy_r <= 1'b0;
            err_r    <= (sq <= QW'(n_r));
            q_r      <= sq - QW'(n_r);
          end
        sstd_pkg::ST_BUILD_INIT: size_r <= SzW'(1);
        sstd_pkg::ST_BUILD_NEXT: begin
          pow_mul_r <= 1'b0;
          pow_r     <= PW'(({1'b0, tab_p} - 10'd1) >> 1);
          if (state_nxt == sstd_pkg::ST_DIVIDE) ready_r <= 1'b1;
        end
        sstd_pkg::ST_BUILD_POW:
          if (dv_done) begin
            if (!pow_mul_r) begin
              r_r       <= dv_r;
              pow_mul_r <= 1'b1;
              // half exponent of one: acc is r itself, finish via product of r*1
              if (pow_r == 9'd1) pow_r <= 9'd0;
              else pow_r <= pow_r - 9'd1;
            end else if (pow_r <= 9'd1) begin
              if (dv_r == 9'd1) size_r <= size_r + 1'b1;
              tab_r <= tab_r + 1'b1;
            end else begin
              pow_r <= pow_r - 9'd1;
            end
          end
        sstd_pkg::ST_DIVIDE:
          if (!err_r && cnt_r != size_r) begin
            if (!dv_busy_r) begin
              dv_busy_r <= 1'b1;
            end else if (dv_done) begin
              if (dv_r == '0) begin
                q_r       <= dv_q;
                e_r       <= e_r + 1'b1;
                dv_busy_r <= 1'b0;
              end else begin
                dv_busy_r <= 1'b0;
                cnt_r     <= cnt_r + 1'b1;
                e_r       <= '0;
              end
            end
          end else cnt_r <= '0;
        sstd_pkg::ST_EMIT:
          if (out_fire) cnt_r <= cnt_r + 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid      = (state_r == sstd_pkg::ST_EMIT);
  assign out_base_prime = err_r ? '0 : c_prime[0];
  assign out_exponent   = err_r ? '0 : c_exp[0];
  assign out_cofactor   = err_r ? '0 : q_r;
  assign out_is_smooth  = !err_r && (q_r == QW'(1));
  assign out_status     = err_r;
  assign out_last       = err_r || (cnt_r == size_r - 1'b1);

endmodule
